[sv/grain_map_lookup_with_lfu_cache_top_defines.svh]
// Assertion macros used by the grain map lookup controller.
`ifndef GRAIN_MAP_LOOKUP_WITH_LFU_CACHE_TOP_DEFINES_SVH
`define GRAIN_MAP_LOOKUP_WITH_LFU_CACHE_TOP_DEFINES_SVH

// Same-cycle implication.
`define GMLC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define GMLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/gmlc_pkg.sv]
// Types and constants shared by the grain map lookup modules.
package gmlc_pkg;

   localparam int GMLC_CACHE_WAYS = 16;
   localparam int GMLC_DIR_DEPTH  = 4096;

   localparam logic [31:0] COUNT_FULL        = 32'hffff_ffff;
   localparam logic [4:0]  GRAIN_SHIFT_MAX   = 5'd16;
   localparam logic [3:0]  TABLE_SHIFT_MAX   = 4'd12;
   localparam logic [4:0]  GRAIN_SHIFT_RESET = 5'd7;
   localparam logic [3:0]  TABLE_SHIFT_RESET = 4'd9;

   typedef enum logic [1:0] {
      CSR_GRAIN_SHIFT = 2'd0,
      CSR_TABLE_SHIFT = 2'd1,
      CSR_DIR_ENTRIES = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_HIT      = 2'd0,
      ST_MISS     = 2'd1,
      ST_UNMAPPED = 2'd2,
      ST_LOAD     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_DECODE,
      CS_MATCH,
      CS_SEARCH,
      CS_UPDATE,
      CS_REPLACE,
      CS_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic decode;
      logic match;
      logic update;
      logic replace;
      logic load_out;
   } gmlc_cmd_type;

   typedef struct packed {
      logic mode_load;
      logic in_range;
      logic tag_zero;
      logic hit;
   } gmlc_stat_type;

endpackage

[sv/gmlc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gmlc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/gmlc_ctrl.sv]
// Sequencer for the grain map lookup: handshakes, phase order, search wait.
`include "grain_map_lookup_with_lfu_cache_top_defines.svh"

module gmlc_ctrl
   import gmlc_pkg::*;
#(
   parameter int CACHE_WAYS = GMLC_CACHE_WAYS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  gmlc_stat_type stat,
   output gmlc_cmd_type  cmd
);

   localparam int LEVELS = $clog2(CACHE_WAYS);
   localparam int SCNT_W = $clog2(LEVELS + 1);
   localparam logic [SCNT_W-1:0] LAST = SCNT_W'(LEVELS - 1);

   ctrl_state_type    state_ff, state_in;
   logic [SCNT_W-1:0] search_cnt_ff, search_cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= CS_IDLE;
         search_cnt_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         search_cnt_ff <= search_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      search_cnt_in = search_cnt_ff;
      cmd           = '0;
      req_stall     = 1'b1;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      case (state_ff)
         CS_IDLE: begin
            // hold off requests while reset is high
            req_stall = reset;
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               state_in    = CS_DECODE;
            end
         end
         CS_DECODE: begin
            cmd.decode = 1'b1;
            if (stat.mode_load || !stat.in_range) begin
               state_in = CS_DONE;
            end else begin
               state_in = CS_MATCH;
            end
         end
         CS_MATCH: begin
            cmd.match = 1'b1;
            if (stat.tag_zero) begin
               state_in = CS_DONE;
            end else if (stat.hit) begin
               state_in = CS_UPDATE;
            end else begin
               search_cnt_in = '0;
               state_in      = CS_SEARCH;
            end
         end
         CS_SEARCH: begin
            // wait for the min tree to settle on the current counts
            if (search_cnt_ff == LAST) begin
               state_in = CS_REPLACE;
            end else begin
               search_cnt_in = search_cnt_ff + 1'b1;
            end
         end
         CS_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = CS_DONE;
         end
         CS_REPLACE: begin
            cmd.replace = 1'b1;
            state_in    = CS_DONE;
         end
         CS_DONE: begin
            // hold until the output register is free or being drained
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `GMLC_ASSERT_SAME(a_load_when_free, clock, reset, cmd.load_out, !rsp_valid_ff || !rsp_stall, "result overwrote a pending transfer")
   `GMLC_ASSERT_NEXT(a_load_shows, clock, reset, cmd.load_out, rsp_valid_ff, "loaded result not offered")
   `GMLC_ASSERT_SAME(a_search_bound, clock, reset, state_ff == CS_SEARCH, search_cnt_ff <= LAST, "search wait overran")
   `GMLC_ASSERT_NEXT(a_capture_busy, clock, reset, cmd.capture, req_stall && state_ff == CS_DECODE, "request not held off after capture")

endmodule

[sv/gmlc_dpath.sv]
// Datapath: config registers, directory memory, tag match, use counts, min tree.
module gmlc_dpath
   import gmlc_pkg::*;
#(
   parameter int CACHE_WAYS = GMLC_CACHE_WAYS,
   parameter int DIR_DEPTH  = GMLC_DIR_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  gmlc_cmd_type  cmd,
   output gmlc_stat_type stat,
   input  logic          req_mode,
   input  logic [31:0]   req_sector,
   input  logic [11:0]   req_dir_slot,
   input  logic [31:0]   req_dir_value,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [12:0]   csr_wdata,
   output logic [1:0]    rsp_status,
   output logic [3:0]    rsp_way,
   output logic [31:0]   rsp_table_sector,
   output logic [11:0]   rsp_table_index,
   output logic [15:0]   rsp_sector_offset
);

   localparam int WAY_W  = $clog2(CACHE_WAYS);
   localparam int WAY_P  = 1 << WAY_W;
   localparam int ADDR_W = $clog2(DIR_DEPTH);
   localparam logic [15:0] ONES16 = 16'hffff;
   localparam logic [11:0] ONES12 = 12'hfff;

   // configuration
   logic [4:0]  grain_shift_ff;
   logic [3:0]  table_shift_ff;
   logic [12:0] dir_entries_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grain_shift_ff <= GRAIN_SHIFT_RESET;
         table_shift_ff <= TABLE_SHIFT_RESET;
         dir_entries_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_GRAIN_SHIFT: grain_shift_ff <= csr_wdata[4:0];
            CSR_TABLE_SHIFT: table_shift_ff <= csr_wdata[3:0];
            CSR_DIR_ENTRIES: dir_entries_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // captured request
   logic        mode_ff;
   logic [31:0] sector_ff;
   logic [11:0] slot_ff;
   logic [31:0] value_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff   <= req_mode;
         sector_ff <= req_sector;
         slot_ff   <= req_dir_slot;
         value_ff  <= req_dir_value;
      end
   end

   // address split
   logic [4:0]  gs;
   logic [3:0]  ts;
   logic [5:0]  split_shift;
   logic [15:0] goff_mask;
   logic [11:0] tidx_mask;
   logic [31:0] after_grain;
   logic [31:0] dir_index;
   logic [31:0] dir_limit;
   logic [31:0] entries32;
   logic [31:0] slot32;
   logic [15:0] goff;
   logic [11:0] tidx;
   logic        slot_ok;

   always_comb begin
      gs          = (grain_shift_ff > GRAIN_SHIFT_MAX) ? GRAIN_SHIFT_MAX : grain_shift_ff;
      ts          = (table_shift_ff > TABLE_SHIFT_MAX) ? TABLE_SHIFT_MAX : table_shift_ff;
      split_shift = {1'b0, gs} + {2'b00, ts};
      goff_mask   = ~(ONES16 << gs);
      tidx_mask   = ~(ONES12 << ts);
      after_grain = sector_ff >> gs;
      goff        = sector_ff[15:0] & goff_mask;
      tidx        = after_grain[11:0] & tidx_mask;
      dir_index   = sector_ff >> split_shift;
      entries32   = {19'b0, dir_entries_ff};
      dir_limit   = (entries32 < 32'(DIR_DEPTH)) ? entries32 : 32'(DIR_DEPTH);
      slot32      = {20'b0, slot_ff};
      slot_ok     = slot32 < 32'(DIR_DEPTH);
   end

   // directory
   logic [31:0] dir_rdata;

   gmlc_ram #(
      .WIDTH(32),
      .DEPTH(DIR_DEPTH)
   ) u_dir_ram (
      .clock  (clock),
      .wr_en  (cmd.decode && mode_ff && slot_ok),
      .wr_addr(slot32[ADDR_W-1:0]),
      .wr_data(value_ff),
      .rd_en  (cmd.decode && !mode_ff && stat.in_range),
      .rd_addr(dir_index[ADDR_W-1:0]),
      .rd_data(dir_rdata)
   );

   // tags and use counts
   logic [31:0]      tag_ff [CACHE_WAYS];
   logic [31:0]      tag_in [CACHE_WAYS];
   logic [31:0]      cnt_ff [CACHE_WAYS];
   logic [31:0]      cnt_in [CACHE_WAYS];
   logic [CACHE_WAYS-1:0] hit_vec;
   logic [WAY_W-1:0] hit_idx_ff, hit_idx_in;
   logic [31:0]      hit_cnt_ff;
   logic [31:0]      match_tag_ff;
   logic [31:0]      cnt_inc;
   logic             halve;
   logic [WAY_W-1:0] victim;

   always_comb begin
      hit_idx_in = '0;
      for (int i = CACHE_WAYS - 1; i >= 0; i--) begin
         hit_vec[i] = (tag_ff[i] == dir_rdata);
         if (hit_vec[i]) begin
            hit_idx_in = WAY_W'(i);
         end
      end
   end

   assign stat.mode_load = mode_ff;
   assign stat.in_range  = dir_index < dir_limit;
   assign stat.tag_zero  = (dir_rdata == '0);
   assign stat.hit       = |hit_vec;

   always_ff @(posedge clock) begin
      if (cmd.match) begin
         match_tag_ff <= dir_rdata;
         hit_idx_ff   <= hit_idx_in;
         hit_cnt_ff   <= cnt_ff[hit_idx_in];
      end
   end

   assign cnt_inc = hit_cnt_ff + 32'd1;
   assign halve   = (cnt_inc == COUNT_FULL);

   always_comb begin
      for (int i = 0; i < CACHE_WAYS; i++) begin
         tag_in[i] = tag_ff[i];
         cnt_in[i] = cnt_ff[i];
         if (cmd.update) begin
            if (hit_idx_ff == WAY_W'(i)) begin
               cnt_in[i] = halve ? (cnt_inc >> 1) : cnt_inc;
            end else if (halve) begin
               cnt_in[i] = cnt_ff[i] >> 1;
            end
         end
         if (cmd.replace && victim == WAY_W'(i)) begin
            tag_in[i] = match_tag_ff;
            cnt_in[i] = 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CACHE_WAYS; i++) begin
            tag_ff[i] <= '0;
            cnt_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < CACHE_WAYS; i++) begin
            tag_ff[i] <= tag_in[i];
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   // registered min tree; ties go left so the lowest way wins
   logic [31:0]      node_cnt [1:2*WAY_P-1];
   logic [WAY_W-1:0] node_idx [1:2*WAY_P-1];
   logic [31:0]      tree_cnt_ff [1:WAY_P-1];
   logic [31:0]      tree_cnt_in [1:WAY_P-1];
   logic [WAY_W-1:0] tree_idx_ff [1:WAY_P-1];
   logic [WAY_W-1:0] tree_idx_in [1:WAY_P-1];

   for (genvar l = 0; l < WAY_P; l++) begin : g_leaf
      if (l < CACHE_WAYS) begin : g_real
         assign node_cnt[WAY_P+l] = cnt_ff[l];
         assign node_idx[WAY_P+l] = WAY_W'(l);
      end else begin : g_pad
         assign node_cnt[WAY_P+l] = COUNT_FULL;
         assign node_idx[WAY_P+l] = '0;
      end
   end

   for (genvar n = 1; n < WAY_P; n++) begin : g_node
      logic take_right;
      assign take_right     = node_cnt[2*n+1] < node_cnt[2*n];
      assign tree_cnt_in[n] = take_right ? node_cnt[2*n+1] : node_cnt[2*n];
      assign tree_idx_in[n] = take_right ? node_idx[2*n+1] : node_idx[2*n];
      always_ff @(posedge clock) begin
         tree_cnt_ff[n] <= tree_cnt_in[n];
         tree_idx_ff[n] <= tree_idx_in[n];
      end
      assign node_cnt[n] = tree_cnt_ff[n];
      assign node_idx[n] = tree_idx_ff[n];
   end

   assign victim = node_idx[1];

   // staged result
   status_type       res_status_ff;
   logic [WAY_W-1:0] res_way_ff;
   logic [31:0]      res_sector_ff;
   logic [11:0]      res_tidx_ff;
   logic [15:0]      res_goff_ff;

   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         // default to unmapped (load for a load); a hit or miss overwrites it later
         res_way_ff    <= '0;
         res_sector_ff <= '0;
         if (mode_ff) begin
            res_status_ff <= ST_LOAD;
            res_tidx_ff   <= '0;
            res_goff_ff   <= '0;
         end else begin
            res_status_ff <= ST_UNMAPPED;
            res_tidx_ff   <= tidx;
            res_goff_ff   <= goff;
         end
      end else if (cmd.update) begin
         res_status_ff <= ST_HIT;
         res_way_ff    <= hit_idx_ff;
         res_sector_ff <= match_tag_ff;
      end else if (cmd.replace) begin
         res_status_ff <= ST_MISS;
         res_way_ff    <= victim;
         res_sector_ff <= match_tag_ff;
      end
   end

   // output register
   status_type       out_status_ff;
   logic [WAY_W+3:0] way_ext;
   logic [3:0]       out_way_ff;
   logic [31:0]      out_sector_ff;
   logic [11:0]      out_tidx_ff;
   logic [15:0]      out_goff_ff;

   assign way_ext = {4'b0000, res_way_ff};

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_status_ff <= res_status_ff;
         out_way_ff    <= way_ext[3:0];
         out_sector_ff <= res_sector_ff;
         out_tidx_ff   <= res_tidx_ff;
         out_goff_ff   <= res_goff_ff;
      end
   end

   assign rsp_status        = out_status_ff;
   assign rsp_way           = out_way_ff;
   assign rsp_table_sector  = out_sector_ff;
   assign rsp_table_index   = out_tidx_ff;
   assign rsp_sector_offset = out_goff_ff;

endmodule

[sv/grain_map_lookup_with_lfu_cache_top.sv]
// Top level of the grain map lookup with least-frequently-used tag cache.
//
//   channel   direction   handshake                    payload
//   req       in          req_valid / req_stall        mode, sector, dir_slot, dir_value
//   rsp       out         rsp_valid / rsp_stall        status, way, table_sector,
//                                                      table_index, sector_offset
//   csr       in          csr_we                       csr_index, csr_wdata
//
// One request at a time. A load or an out-of-range translate goes from decode to the
// result, a zero directory entry ends at the tag match, a hit adds a count update and
// a miss waits for the registered min tree over the use counts to pick the victim way.
// Reset is synchronous; it resets the tags, counts and config, not the directory.
// The result sits in an output register, so a stalled rsp side only holds a request in
// its done state, and the next request waits until that register is free or drained.
module grain_map_lookup_with_lfu_cache_top
   import gmlc_pkg::*;
#(
   parameter int CACHE_WAYS = GMLC_CACHE_WAYS,
   parameter int DIR_DEPTH  = GMLC_DIR_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [31:0] req_sector,
   input  logic [11:0] req_dir_slot,
   input  logic [31:0] req_dir_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_way,
   output logic [31:0] rsp_table_sector,
   output logic [11:0] rsp_table_index,
   output logic [15:0] rsp_sector_offset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);

   gmlc_cmd_type  cmd;
   gmlc_stat_type stat;

   gmlc_ctrl #(
      .CACHE_WAYS(CACHE_WAYS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .stat     (stat),
      .cmd      (cmd)
   );

   gmlc_dpath #(
      .CACHE_WAYS(CACHE_WAYS),
      .DIR_DEPTH (DIR_DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_mode         (req_mode),
      .req_sector       (req_sector),
      .req_dir_slot     (req_dir_slot),
      .req_dir_value    (req_dir_value),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_status       (rsp_status),
      .rsp_way          (rsp_way),
      .rsp_table_sector (rsp_table_sector),
      .rsp_table_index  (rsp_table_index),
      .rsp_sector_offset(rsp_sector_offset)
   );

endmodule

[test/grain_map_lookup_with_lfu_cache_top_tb.sv]
// Testbench for the grain map lookup with LFU tag cache: random traffic checked by a scoreboard.
module grain_map_lookup_with_lfu_cache_top_tb import gmlc_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 500_000;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 240;
   localparam int POOL_SIZE     = 24;
   localparam int DRAIN_CYCLES  = 20;

   typedef struct {
      status_type  status;
      logic [3:0]  way;
      logic [31:0] table_sector;
      logic [11:0] table_index;
      logic [15:0] sector_offset;
   } lookup_result_type;

   class lfu_lookup_scoreboard;
      logic [4:0]        grain_shift;
      logic [3:0]        table_shift;
      logic [12:0]       dir_entries;
      logic [31:0]       directory [GMLC_DIR_DEPTH];
      bit                dir_written [GMLC_DIR_DEPTH];
      logic [31:0]       way_tags [GMLC_CACHE_WAYS];
      logic [31:0]       use_counts [GMLC_CACHE_WAYS];
      lookup_result_type pending_lookups [$];
      int                errors;

      function new();
         grain_shift = GRAIN_SHIFT_RESET;
         table_shift = TABLE_SHIFT_RESET;
         dir_entries = '0;
         errors = 0;
         foreach (dir_written[i]) dir_written[i] = 1'b0;
         foreach (way_tags[i]) begin
            way_tags[i] = '0;
            use_counts[i] = '0;
         end
      endfunction

      function void write_register(csr_index_type idx, logic [12:0] value);
         case (idx)
            CSR_GRAIN_SHIFT: grain_shift = value[4:0];
            CSR_TABLE_SHIFT: table_shift = value[3:0];
            CSR_DIR_ENTRIES: dir_entries = value;
            default: ;
         endcase
      endfunction

      function int eff_grain_shift();
         return (grain_shift > GRAIN_SHIFT_MAX) ? int'(GRAIN_SHIFT_MAX) : int'(grain_shift);
      endfunction

      function int eff_table_shift();
         return (table_shift > TABLE_SHIFT_MAX) ? int'(TABLE_SHIFT_MAX) : int'(table_shift);
      endfunction

      function int dir_limit();
         return (dir_entries < GMLC_DIR_DEPTH) ? int'(dir_entries) : GMLC_DIR_DEPTH;
      endfunction

      // Advance the cache model by one accepted request and queue its result.
      function void accept_request(logic mode, logic [31:0] sector, logic [11:0] slot,
                                   logic [31:0] value);
         lookup_result_type r;
         int                gs;
         int                ts;
         logic [63:0]       s64;
         logic [63:0]       g_off;
         logic [63:0]       t_idx;
         logic [63:0]       d_idx;
         logic [31:0]       tag;
         logic [31:0]       best;
         int                hit;
         int                victim;

         r.status = ST_LOAD;
         r.way = '0;
         r.table_sector = '0;
         r.table_index = '0;
         r.sector_offset = '0;
         if (mode) begin
            directory[slot] = value;
            dir_written[slot] = 1'b1;
         end else begin
            gs = eff_grain_shift();
            ts = eff_table_shift();
            s64 = {32'd0, sector};
            g_off = s64 & ((64'd1 << gs) - 64'd1);
            t_idx = (s64 >> gs) & ((64'd1 << ts) - 64'd1);
            d_idx = s64 >> (gs + ts);
            r.table_index = t_idx[11:0];
            r.sector_offset = g_off[15:0];
            tag = (d_idx < 64'(dir_limit())) ? directory[d_idx[11:0]] : '0;
            if (tag == '0) begin
               r.status = ST_UNMAPPED;
            end else begin
               hit = -1;
               for (int i = 0; i < GMLC_CACHE_WAYS; i++) begin
                  if (hit < 0 && way_tags[i] == tag) hit = i;
               end
               r.table_sector = tag;
               if (hit >= 0) begin
                  use_counts[hit] = use_counts[hit] + 32'd1;
                  if (use_counts[hit] == COUNT_FULL) begin
                     foreach (use_counts[i]) use_counts[i] = use_counts[i] >> 1;
                  end
                  r.status = ST_HIT;
                  r.way = 4'(hit);
               end else begin
                  // claim the first way with the lowest count
                  victim = 0;
                  best = COUNT_FULL;
                  for (int i = 0; i < GMLC_CACHE_WAYS; i++) begin
                     if (use_counts[i] < best) begin
                        best = use_counts[i];
                        victim = i;
                     end
                  end
                  way_tags[victim] = tag;
                  use_counts[victim] = 32'd1;
                  r.status = ST_MISS;
                  r.way = 4'(victim);
               end
            end
         end
         pending_lookups.push_back(r);
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         errors++;
      endtask

      task check_response(logic [1:0] status, logic [3:0] way, logic [31:0] table_sector,
                          logic [11:0] table_index, logic [15:0] sector_offset);
         lookup_result_type e;
         if (pending_lookups.size() == 0) begin
            report($sformatf("result with nothing pending, status %0d", status));
            return;
         end
         e = pending_lookups.pop_front();
         if (status !== e.status)
            report($sformatf("status %0d, expected %0d", status, e.status));
         if (way !== e.way)
            report($sformatf("way %0d, expected %0d", way, e.way));
         if (table_sector !== e.table_sector)
            report($sformatf("table_sector %h, expected %h", table_sector, e.table_sector));
         if (table_index !== e.table_index)
            report($sformatf("table_index %h, expected %h", table_index, e.table_index));
         if (sector_offset !== e.sector_offset)
            report($sformatf("sector_offset %h, expected %h", sector_offset,
                             e.sector_offset));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_mode = 1'b0;
   logic [31:0] req_sector = '0;
   logic [11:0] req_dir_slot = '0;
   logic [31:0] req_dir_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_way;
   logic [31:0] rsp_table_sector;
   logic [11:0] rsp_table_index;
   logic [15:0] rsp_sector_offset;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [12:0] csr_wdata = '0;

   lfu_lookup_scoreboard sb = new();
   int          gap_pct = 0;
   int          stall_pct = 0;
   int          stall_left = 0;
   int unsigned cycle_count = 0;
   int          written_slots [$];
   logic [31:0] tag_pool [POOL_SIZE];

   grain_map_lookup_with_lfu_cache_top dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // stall the result side in short bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_status, rsp_way, rsp_table_sector, rsp_table_index,
                           rsp_sector_offset);
   end

   task automatic drive_req(logic mode, logic [31:0] sector, logic [11:0] slot,
                            logic [31:0] value);
      int idle_n;
      if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
         idle_n = $urandom_range(1, 4);
         @(negedge clock) req_valid <= 1'b0;
         repeat (idle_n - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_sector <= sector;
      req_dir_slot <= slot;
      req_dir_value <= value;
      do @(posedge clock); while (req_stall);
      if (mode && !sb.dir_written[slot]) written_slots.push_back(int'(slot));
      sb.accept_request(mode, sector, slot, value);
   endtask

   task automatic send_load(logic [11:0] slot, logic [31:0] value);
      drive_req(1'b1, $urandom, slot, value);
   endtask

   task automatic send_lookup(logic [31:0] sector);
      drive_req(1'b0, sector, 12'($urandom), $urandom);
   endtask

   // drop valid and wait until every pending transfer has come back
   task automatic settle();
      @(negedge clock) req_valid <= 1'b0;
      while (sb.pending_lookups.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [12:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock) csr_we <= 1'b0;
      sb.write_register(idx, value);
   endtask

   task automatic configure(logic [12:0] gs, logic [12:0] ts, logic [12:0] entries);
      settle();
      write_csr(CSR_GRAIN_SHIFT, gs);
      write_csr(CSR_TABLE_SHIFT, ts);
      write_csr(CSR_DIR_ENTRIES, entries);
   endtask

   // Never hit an in-range directory slot that has not been loaded yet.
   function automatic logic [31:0] pick_sector();
      int          sh;
      int          lim;
      int          s;
      logic [63:0] cand;
      logic [31:0] sec;
      sh = sb.eff_grain_shift() + sb.eff_table_shift();
      lim = sb.dir_limit();
      if ($urandom_range(0, 9) < 7 && written_slots.size() > 0) begin
         for (int tries = 0; tries < 16; tries++) begin
            s = written_slots[$urandom_range(0, written_slots.size() - 1)];
            if (s < lim && (64'(s) << sh) < 64'h1_0000_0000) begin
               cand = (64'(s) << sh) | (64'($urandom) & ((64'd1 << sh) - 64'd1));
               return cand[31:0];
            end
         end
      end
      for (int tries = 0; tries < 16; tries++) begin
         case ($urandom_range(0, 3))
            0: sec = $urandom;
            1: sec = $urandom_range(0, 8191);
            2: sec = 32'hffff_ffff;
            default: sec = $urandom >> $urandom_range(0, 31);
         endcase
         if ((64'(sec) >> sh) >= 64'(lim) || sb.dir_written[sec >> sh]) return sec;
      end
      return 32'd0;
   endfunction

   task automatic random_phase(int items);
      int          slot;
      logic [31:0] value;
      repeat (items) begin
         if ($urandom_range(0, 3) == 0) begin
            slot = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 31);
            case ($urandom_range(0, 19))
               0, 1: value = '0;
               2: value = $urandom;
               default: value = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
            endcase
            send_load(12'(slot), value);
         end else begin
            send_lookup(pick_sector());
         end
      end
   endtask

   initial begin
      logic [12:0] gs;
      logic [12:0] ts;
      logic [12:0] entries;

      tag_pool[0] = 32'hffff_ffff;
      tag_pool[1] = 32'h0000_0001;
      tag_pool[2] = 32'h8000_0000;
      for (int i = 3; i < POOL_SIZE; i++) begin
         tag_pool[i] = $urandom;
         if (tag_pool[i] == '0) tag_pool[i] = 32'h5a5a_0001;
      end

      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      gap_pct = 25;
      stall_pct = 25;
      // slot 0 goes first so that a fallback sector of zero is always safe
      send_load(12'd0, tag_pool[3]);
      send_load(12'd1, tag_pool[2]);
      send_load(12'd2, 32'd0);
      send_load(12'd3, tag_pool[3]);
      send_load(12'd15, tag_pool[1]);
      send_load(12'hfff, 32'hffff_ffff);
      // empty directory: everything is unmapped
      send_lookup(32'd0);
      send_lookup(32'hffff_ffff);

      configure(13'd0, 13'd0, 13'd4096);
      send_lookup(32'd4095);
      send_lookup(32'd0);
      send_lookup(32'd3);
      send_lookup(32'd1);
      send_lookup(32'd2);
      send_lookup(32'd4096);
      send_lookup(32'hffff_ffff);

      // oversized shifts clamp to the widest grain and table
      configure(13'd31, 13'd15, 13'd8191);
      send_lookup(32'hffff_ffff);
      send_lookup(32'h0fff_ffff);
      send_lookup(32'h3000_0000);
      send_lookup(32'h2000_0000);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin gs = 13'd7;  ts = 13'd9;  entries = 13'd64;   end
            1: begin gs = 13'd0;  ts = 13'd0;  entries = 13'd8191; end
            2: begin gs = 13'd16; ts = 13'd12; entries = 13'd4096; end
            3: begin gs = 13'd31; ts = 13'd15; entries = 13'd4095; end
            5: begin gs = 13'd2;  ts = 13'd1;  entries = 13'd1;    end
            default: begin
               gs = $urandom_range(0, 1) ? 13'($urandom_range(0, 8))
                                         : 13'($urandom_range(0, 31));
               ts = 13'($urandom_range(0, 15));
               entries = ($urandom_range(0, 3) == 0) ? 13'($urandom_range(0, 8191))
                                                      : 13'($urandom_range(1, 48));
            end
         endcase
         configure(gs, ts, entries);
         case (p)
            1: begin gap_pct = 0;  stall_pct = 0;  end
            2: begin gap_pct = 50; stall_pct = 10; end
            3: begin gap_pct = 10; stall_pct = 50; end
            default: begin
               gap_pct = 25 * $urandom_range(0, 2);
               stall_pct = 25 * $urandom_range(0, 2);
            end
         endcase
         // keep the tail of the run free of idling
         if (p == RANDOM_PHASES - 1) begin
            gap_pct = 0;
            stall_pct = 0;
         end
         random_phase(PHASE_ITEMS);
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
